>>> rtl/sorted_range_list_insert_prune_macros.svh
// Assertion macros used by the sorted range list top level.
`ifndef SORTED_RANGE_LIST_INSERT_PRUNE_MACROS_SVH
`define SORTED_RANGE_LIST_INSERT_PRUNE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SRLIP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorted range list: assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SRLIP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted range list: assertion failed");

`endif

>>> rtl/srlip_pkg.sv
// Types and constants shared by the sorted range list cells and top level.
`default_nettype none
package srlip_pkg;

    localparam int ADDR_W  = 64;
    localparam int IDX_W   = 4;
    localparam int TOTAL_W = 5;
    localparam int READ_N  = 16;

    typedef enum logic [1:0] {
        K_INSERT = 2'd0,
        K_PRUNE  = 2'd1,
        K_READ   = 2'd2,
        K_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADWIN = 2'd2,
        ST_RANGE  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD    = 2'd0,
        OP_INSERT  = 2'd1,
        OP_CLIP    = 2'd2,
        OP_COMPACT = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] end_addr;
    } t_entry;

    // Broadcast to every cell: the operation and its two bounds.
    typedef struct packed {
        t_cell_op          op;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
    } t_cell_cmd;

    // Per-cell position flags, derived from the count and the compaction phase.
    typedef struct packed {
        logic in_use;
        logic at_count;
        logic lower;
        logic upper;
    } t_cell_ctl;

endpackage
`default_nettype wire

>>> rtl/srlip_cell.sv
// One table cell: holds a single range and exchanges it with its neighbours.
`default_nettype none
module srlip_cell
    import srlip_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_cmd i_cmd,
    input  wire t_cell_ctl i_ctl,
    input  wire t_entry    i_prev_ent,
    input  wire logic      i_prev_gt,
    input  wire logic      i_prev_keep,
    input  wire t_entry    i_next_ent,
    input  wire logic      i_next_keep,
    output t_entry         o_ent,
    output logic           o_gt,
    output logic           o_keep
);

    t_entry r_ent;
    logic   r_keep;
    t_entry w_new;
    t_entry w_clip;
    logic   w_keep;

    assign w_new  = '{start_addr: i_cmd.lo, end_addr: i_cmd.hi};
    assign o_gt   = i_ctl.in_use && (r_ent.start_addr > i_cmd.lo);

    // Stored ranges always have start not above end, so a range that meets the
    // window cannot turn empty when clipped.
    assign w_keep = i_ctl.in_use && !(r_ent.end_addr < i_cmd.lo)
                    && !(r_ent.start_addr > i_cmd.hi);
    assign w_clip.start_addr = (r_ent.start_addr < i_cmd.lo) ? i_cmd.lo : r_ent.start_addr;
    assign w_clip.end_addr   = (r_ent.end_addr > i_cmd.hi) ? i_cmd.hi : r_ent.end_addr;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_INSERT: begin
                // Entries above the new start move up one place; the gap takes the new range.
                if (o_gt || i_ctl.at_count) begin
                    r_ent <= i_prev_gt ? i_prev_ent : w_new;
                end
            end
            OP_CLIP: begin
                r_ent <= w_clip;
            end
            OP_COMPACT: begin
                if (i_ctl.lower && !r_keep && i_next_keep) begin
                    r_ent <= i_next_ent;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_CLIP: begin
                    r_keep <= w_keep;
                end
                OP_COMPACT: begin
                    // A hole below a kept entry swaps with it, so kept entries never reorder.
                    if (i_ctl.lower && !r_keep && i_next_keep) begin
                        r_keep <= 1'b1;
                    end else if (i_ctl.upper && !i_prev_keep && r_keep) begin
                        r_keep <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_ent  = r_ent;
    assign o_keep = r_keep;

endmodule
`default_nettype wire

>>> rtl/sorted_range_list_insert_prune.sv
// Sorted range table built as a row of cells, one range per cell.
// Read, clear, a rejected insert (table full) and a rejected prune (reversed
// window) answer in the cycle after the transaction is accepted. An insert
// first orders the bounds, then every cell compares its start with the new one
// and the row shifts up by one place in a single step. A prune first clips all
// cells in parallel, then DEPTH rounds of neighbour swaps (alternating even and
// odd pairs) push the deleted entries to the top while a shift register counts
// the survivors. busy is high while an operation is in progress. Every
// transaction produces exactly one result, shown for one cycle with o_done
// high; it is not held, so the receiver must capture it in that cycle.
`default_nettype none
`include "sorted_range_list_insert_prune_macros.svh"
module sorted_range_list_insert_prune
    import srlip_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          i_kind,
    input  wire logic [ADDR_W-1:0]   i_range_low,
    input  wire logic [ADDR_W-1:0]   i_range_high,
    input  wire logic [IDX_W-1:0]    i_read_index,
    output logic                     o_done,
    output logic [1:0]               o_status,
    output logic [TOTAL_W-1:0]       o_entry_total,
    output logic [ADDR_W-1:0]        o_entry_start,
    output logic [ADDR_W-1:0]        o_entry_end
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int RW   = $clog2(DEPTH);
    localparam int IW   = (CW > IDX_W) ? CW : IDX_W;
    localparam int RD_N = (DEPTH < READ_N) ? DEPTH : READ_N;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_CLIP,
        S_COMPACT
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [ADDR_W-1:0] r_lo, n_lo;
    logic [ADDR_W-1:0] r_hi, n_hi;
    logic [RW-1:0]     r_round, n_round;
    logic [DEPTH-1:0]  r_scan, n_scan;
    logic [CW-1:0]     r_kept, n_kept;
    logic              r_done, n_done;
    t_status           r_status, n_status;
    logic [ADDR_W-1:0] r_start, n_start;
    logic [ADDR_W-1:0] r_end, n_end;

    t_cell_cmd         w_cmd;
    t_entry            w_ent [DEPTH];
    logic [DEPTH-1:0]  w_gt;
    logic [DEPTH-1:0]  w_keep;
    logic              w_phase;
    t_kind             w_kind;
    t_entry            w_rd;
    logic              w_rd_ok;

    assign w_phase = r_round[0];
    assign w_kind  = t_kind'(i_kind);

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_ctl w_ctl;
        t_entry    w_prev_ent;
        logic      w_prev_gt;
        logic      w_prev_keep;
        t_entry    w_next_ent;
        logic      w_next_keep;

        assign w_ctl.in_use   = CW'(g) < r_count;
        assign w_ctl.at_count = CW'(g) == r_count;
        assign w_ctl.lower    = (g < DEPTH - 1) && (1'(g % 2) == w_phase);
        assign w_ctl.upper    = (g > 0) && (1'(g % 2) != w_phase);

        if (g == 0) begin : g_first
            assign w_prev_ent  = '0;
            assign w_prev_gt   = 1'b0;
            assign w_prev_keep = 1'b1;
        end else begin : g_mid
            assign w_prev_ent  = w_ent[g-1];
            assign w_prev_gt   = w_gt[g-1];
            assign w_prev_keep = w_keep[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_next_ent  = '0;
            assign w_next_keep = 1'b0;
        end else begin : g_inner
            assign w_next_ent  = w_ent[g+1];
            assign w_next_keep = w_keep[g+1];
        end

        srlip_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_ctl       (w_ctl),
            .i_prev_ent  (w_prev_ent),
            .i_prev_gt   (w_prev_gt),
            .i_prev_keep (w_prev_keep),
            .i_next_ent  (w_next_ent),
            .i_next_keep (w_next_keep),
            .o_ent       (w_ent[g]),
            .o_gt        (w_gt[g]),
            .o_keep      (w_keep[g])
        );
    end

    // Read port: only the first sixteen positions (or DEPTH, if fewer) are addressable.
    always_comb begin
        w_rd = '0;
        for (int k = 0; k < RD_N; k++) begin
            if (i_read_index == IDX_W'(k)) begin
                w_rd = w_ent[k];
            end
        end
    end
    assign w_rd_ok = IW'(i_read_index) < IW'(r_count);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_round   = r_round;
        n_scan    = r_scan;
        n_kept    = r_kept;
        n_done    = 1'b0;
        n_status  = ST_OK;
        n_start   = '0;
        n_end     = '0;
        w_cmd.op  = OP_HOLD;
        w_cmd.lo  = r_lo;
        w_cmd.hi  = r_hi;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (w_kind)
                        K_INSERT: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_done   = 1'b1;
                                n_status = ST_FULL;
                            end else if (i_range_high < i_range_low) begin
                                n_lo    = i_range_high;
                                n_hi    = i_range_low;
                                n_state = S_INSERT;
                            end else begin
                                n_lo    = i_range_low;
                                n_hi    = i_range_high;
                                n_state = S_INSERT;
                            end
                        end
                        K_PRUNE: begin
                            if (i_range_high < i_range_low) begin
                                n_done   = 1'b1;
                                n_status = ST_BADWIN;
                            end else begin
                                n_lo    = i_range_low;
                                n_hi    = i_range_high;
                                n_state = S_CLIP;
                            end
                        end
                        K_READ: begin
                            n_done = 1'b1;
                            if (w_rd_ok) begin
                                n_start = w_rd.start_addr;
                                n_end   = w_rd.end_addr;
                            end else begin
                                n_status = ST_RANGE;
                            end
                        end
                        K_CLEAR: begin
                            n_done  = 1'b1;
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INSERT: begin
                w_cmd.op = OP_INSERT;
                n_count  = r_count + CW'(1);
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end
            S_CLIP: begin
                w_cmd.op = OP_CLIP;
                n_round  = '0;
                n_state  = S_COMPACT;
            end
            S_COMPACT: begin
                w_cmd.op = OP_COMPACT;
                // The survivor count is taken from a snapshot of the keep bits.
                if (r_round == '0) begin
                    n_scan = w_keep >> 1;
                    n_kept = CW'(w_keep[0]);
                end else begin
                    n_scan = r_scan >> 1;
                    n_kept = r_kept + CW'(r_scan[0]);
                end
                n_round = r_round + RW'(1);
                if (r_round == RW'(DEPTH - 1)) begin
                    n_count = n_kept;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_round  <= '0;
            r_kept   <= '0;
            r_done   <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_round  <= n_round;
            r_kept   <= n_kept;
            r_done   <= n_done;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_scan  <= n_scan;
        r_start <= n_start;
        r_end   <= n_end;
    end

    assign busy          = r_state != S_IDLE;
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_entry_total = TOTAL_W'(r_count);
    assign o_entry_start = r_start;
    assign o_entry_end   = r_end;

    `SRLIP_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CW'(DEPTH))
    `SRLIP_ASSERT_IMP(a_no_done_busy, r_state != S_IDLE, !r_done)
    `SRLIP_ASSERT_NXT(a_insert_one_step, r_state == S_INSERT, r_done && r_state == S_IDLE)
    `SRLIP_ASSERT_NXT(a_full_reject, start && !busy && w_kind == K_INSERT && r_count == CW'(DEPTH), r_done && r_status == ST_FULL && r_state == S_IDLE)
    `SRLIP_ASSERT_NXT(a_compact_ends, r_state == S_COMPACT && r_round == RW'(DEPTH - 1), r_done && r_state == S_IDLE && r_status == ST_OK)

endmodule
`default_nettype wire
